// ===== rtl/hcbp_pkg.sv =====
// Package: shared types and constants for the code bit packer.
`timescale 1ns / 1ps
package hcbp_pkg;

    localparam int BYTE_BITS   = 8;
    localparam int TABLE_DEPTH = 256;
    localparam int SYM_W       = 8;
    localparam int CODE_W      = 32;
    localparam int IN_LEN_W    = 6;
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        ACT_LOAD   = 2'd0,
        ACT_ENCODE = 2'd1,
        ACT_FLUSH  = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic {
        OP_ENCODE = 1'b0,
        OP_FLUSH  = 1'b1
    } op_kind_t;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_EMIT = 1'b1
    } back_state_t;

endpackage

// ===== rtl/hcbp_fifo.sv =====
// Short register queue between the front and back parts.
`timescale 1ns / 1ps
module hcbp_fifo #(
    parameter int DATA_W = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push_valid,
    output logic              push_ready,
    input  logic [DATA_W-1:0] push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output logic [DATA_W-1:0] pop_data
);
    import hcbp_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    logic [DATA_W-1:0] slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic              do_push, do_pop;

    assign push_ready = (fill_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop) begin
            fill_next = fill_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/hcbp_front.sv =====
// Front part: accepts transactions, owns the code table and queues operations.
`timescale 1ns / 1ps
module hcbp_front #(
    parameter int MAX_CODE_LEN = 32
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [1:0]                 s_tuser,
    input  logic [hcbp_pkg::SYM_W-1:0] sym,
    input  logic [hcbp_pkg::CODE_W-1:0] code_value,
    input  logic [hcbp_pkg::IN_LEN_W-1:0] code_length,
    output logic                       push_valid,
    input  logic                       push_ready,
    output logic [MAX_CODE_LEN+$clog2(MAX_CODE_LEN+1)+7:0] push_data
);
    import hcbp_pkg::*;

    localparam int LEN_W   = $clog2(MAX_CODE_LEN + 1);
    localparam int WBUF_W  = MAX_CODE_LEN + 7;
    localparam int SH_W    = $clog2(WBUF_W + 1);
    localparam int WIDE_W  = WBUF_W + CODE_W;

    action_t               action;
    logic                  accept;
    logic [LEN_W-1:0]      len_sat;

    logic [LEN_W+CODE_W-1:0] mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]  valid_reg;
    logic [LEN_W+CODE_W-1:0] rd_entry_reg;
    logic                    rd_valid_reg;
    logic                    hold_valid_reg, hold_valid_next;
    op_kind_t                hold_kind_reg;

    logic [LEN_W-1:0]      len_eff;
    logic [SH_W-1:0]       shift_amt;
    logic [WIDE_W-1:0]     code_wide;
    logic [WIDE_W-1:0]     code_shifted;

    assign action   = action_t'(s_tuser);
    assign s_tready = !hold_valid_reg || push_ready;
    assign accept   = s_tvalid && s_tready;
    assign len_sat  = (code_length > IN_LEN_W'(MAX_CODE_LEN)) ?
                      LEN_W'(MAX_CODE_LEN) : LEN_W'(code_length);

    // table write on load, registered read on encode
    always_ff @(posedge aclk) begin
        if (accept && action == ACT_LOAD) begin
            mem[sym] <= {len_sat, code_value};
        end
        if (accept && action == ACT_ENCODE) begin
            rd_entry_reg <= mem[sym];
            rd_valid_reg <= valid_reg[sym];
        end
        if (accept) begin
            hold_kind_reg <= (action == ACT_FLUSH) ? OP_FLUSH : OP_ENCODE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (accept && action == ACT_LOAD) begin
            valid_reg[sym] <= 1'b1;
        end
    end

    always_comb begin
        hold_valid_next = hold_valid_reg;
        if (push_valid && push_ready) begin
            hold_valid_next = 1'b0;
        end
        if (accept && (action == ACT_ENCODE || action == ACT_FLUSH)) begin
            hold_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    // left-align the code in the accumulator width; bits above the length drop off
    always_comb begin
        len_eff = (hold_kind_reg == OP_ENCODE && rd_valid_reg) ?
                  rd_entry_reg[CODE_W +: LEN_W] : '0;
        shift_amt    = SH_W'(WBUF_W) - SH_W'(len_eff);
        code_wide    = {{WBUF_W{1'b0}}, rd_entry_reg[CODE_W-1:0]};
        code_shifted = code_wide << shift_amt;
    end

    assign push_valid = hold_valid_reg;
    assign push_data  = {hold_kind_reg, len_eff, code_shifted[WBUF_W-1:0]};

endmodule

// ===== rtl/hcbp_back.sv =====
// Back part: bit accumulator and byte emitter with output register.
`timescale 1ns / 1ps
module hcbp_back #(
    parameter int MAX_CODE_LEN = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        pop_valid,
    output logic        pop_ready,
    input  logic [MAX_CODE_LEN+$clog2(MAX_CODE_LEN+1)+7:0] pop_data,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,
    output logic        m_tlast
);
    import hcbp_pkg::*;

    localparam int LEN_W  = $clog2(MAX_CODE_LEN + 1);
    localparam int WBUF_W = MAX_CODE_LEN + 7;
    localparam int CNT_W  = $clog2(WBUF_W + 1);

    back_state_t         state_reg, state_next;
    logic [WBUF_W-1:0]   wbuf_reg, wbuf_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [7:0]          m_tdata_reg, m_tdata_next;
    logic                m_tlast_reg, m_tlast_next;

    op_kind_t            op_kind;
    logic [LEN_W-1:0]    op_len;
    logic [WBUF_W-1:0]   op_code;
    logic                out_free;
    logic [CNT_W-1:0]    cnt_sum;
    logic [CNT_W-1:0]    cnt_rem;

    assign op_kind  = op_kind_t'(pop_data[WBUF_W+LEN_W]);
    assign op_len   = pop_data[WBUF_W +: LEN_W];
    assign op_code  = pop_data[WBUF_W-1:0];
    assign out_free = !m_tvalid_reg || m_tready;
    assign cnt_sum  = cnt_reg + CNT_W'(op_len);
    assign cnt_rem  = cnt_reg - CNT_W'(BYTE_BITS);

    always_comb begin
        state_next    = state_reg;
        wbuf_next     = wbuf_reg;
        cnt_next      = cnt_reg;
        pop_ready     = 1'b0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        case (state_reg)
            BK_IDLE: begin
                if (pop_valid) begin
                    if (op_kind == OP_FLUSH) begin
                        if (out_free) begin
                            pop_ready     = 1'b1;
                            m_tvalid_next = 1'b1;
                            m_tdata_next  = wbuf_reg[WBUF_W-1 -: 8];
                            m_tlast_next  = 1'b1;
                            wbuf_next     = '0;
                            cnt_next      = '0;
                        end
                    end else begin
                        pop_ready = 1'b1;
                        wbuf_next = wbuf_reg | (op_code >> cnt_reg);
                        cnt_next  = cnt_sum;
                        if (cnt_sum >= CNT_W'(BYTE_BITS)) begin
                            state_next = BK_EMIT;
                        end
                    end
                end
            end
            BK_EMIT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = wbuf_reg[WBUF_W-1 -: 8];
                    m_tlast_next  = (cnt_rem < CNT_W'(BYTE_BITS));
                    wbuf_next     = wbuf_reg << BYTE_BITS;
                    cnt_next      = cnt_rem;
                    if (cnt_rem < CNT_W'(BYTE_BITS)) begin
                        state_next = BK_IDLE;
                    end
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= BK_IDLE;
            wbuf_reg     <= '0;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            wbuf_reg     <= wbuf_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

// ===== rtl/huffman_code_bit_packer_top.sv =====
// Top level: variable-length code bit packer.
// Input stream: tuser carries the action (load, encode, flush, none); tdata carries
// the symbol, the code bits and the code length. A load writes one entry of the
// 256-entry code table, an encode appends the symbol's code to the bit
// accumulator, a flush pads pending bits with zeros and sends exactly one byte.
// Output stream: one packed byte per transaction, earliest code bit in bit 7,
// tlast on the final byte produced by an input transaction.
// The front part takes one transaction per cycle while its hold stage and the
// four-entry queue have room. The back part takes an encode into the bit
// accumulator, then sends each byte it completes (up to four with a 32-bit
// maximum code length) and takes no new operation until they are sent; a
// flush and each byte wait for the single output byte register to be free.
// An encode passes the hold stage, queue, accumulator and output register.
// Reset clears the table valid flags, the accumulator, the queue and the output.
// While m_tready is low the output byte holds, the back part stops once it has
// a byte or a flush to send, and the queue fills until s_tready drops.
`timescale 1ns / 1ps
module huffman_code_bit_packer_top #(
    parameter int MAX_CODE_LEN = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // symbol[7:0], code_value[39:8], code_length[45:40], zero
    input  logic [1:0]  s_tuser,   // action[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // packed_byte[7:0]
    output logic        m_tlast
);
    import hcbp_pkg::*;

    localparam int LEN_W   = $clog2(MAX_CODE_LEN + 1);
    localparam int WBUF_W  = MAX_CODE_LEN + 7;
    localparam int ENTRY_W = 1 + LEN_W + WBUF_W;

    logic               push_valid, push_ready;
    logic [ENTRY_W-1:0] push_data;
    logic               pop_valid, pop_ready;
    logic [ENTRY_W-1:0] pop_data;

    hcbp_front #(
        .MAX_CODE_LEN(MAX_CODE_LEN)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tuser    (s_tuser),
        .sym        (s_tdata[7:0]),
        .code_value (s_tdata[39:8]),
        .code_length(s_tdata[45:40]),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    hcbp_fifo #(
        .DATA_W(ENTRY_W)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_data (push_data),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data)
    );

    hcbp_back #(
        .MAX_CODE_LEN(MAX_CODE_LEN)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .pop_valid(pop_valid),
        .pop_ready(pop_ready),
        .pop_data (pop_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== test/huffman_code_bit_packer_checker.sv =====
// Checker: watches both channels, predicts the packed byte stream and compares it.
`timescale 1ns / 1ps
module huffman_code_bit_packer_checker #(
    parameter int MAX_CODE_LEN = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,   // symbol[7:0], code_value[39:8], code_length[45:40], zero
    input  logic [1:0]  s_tuser,   // action[1:0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,   // packed_byte[7:0]
    input  logic        m_tlast,
    output int          bytes_awaited,
    output int          mismatches
);
    import hcbp_pkg::*;

    typedef struct packed {
        logic [7:0] packed_byte;
        logic       last;
    } packed_out_t;

    logic [CODE_W-1:0] code_bits [TABLE_DEPTH];
    logic [5:0]        code_len  [TABLE_DEPTH];
    logic [6:0]        acc_bits;
    logic [2:0]        acc_count;
    packed_out_t       expected_bytes [$];

    initial begin
        bytes_awaited = 0;
        mismatches    = 0;
    end

    task automatic predict_packed_bytes(input action_t act, input logic [7:0] sym,
                                        input logic [31:0] val, input logic [5:0] len);
        logic [7:0]  shreg;
        int          cnt;
        int          nbytes;
        int          made;
        int          eff_len;
        packed_out_t item;
        case (act)
            ACT_LOAD: begin
                code_bits[sym] = val;
                code_len[sym]  = (len > MAX_CODE_LEN) ? 6'(MAX_CODE_LEN) : len;
            end
            ACT_ENCODE: begin
                eff_len = code_len[sym];
                shreg   = {1'b0, acc_bits};
                cnt     = acc_count;
                nbytes  = (cnt + eff_len) / BYTE_BITS;
                made    = 0;
                for (int i = eff_len - 1; i >= 0; i--) begin
                    shreg = {shreg[6:0], (i < CODE_W) ? code_bits[sym][i] : 1'b0};
                    cnt++;
                    if (cnt == BYTE_BITS) begin
                        made++;
                        item.packed_byte = shreg;
                        item.last        = (made == nbytes);
                        expected_bytes.push_back(item);
                        shreg = '0;
                        cnt   = 0;
                    end
                end
                acc_bits  = shreg[6:0];
                acc_count = 3'(cnt);
            end
            ACT_FLUSH: begin
                // pad on the right; nothing pending gives a zero byte
                item.packed_byte = 8'({1'b0, acc_bits} << (BYTE_BITS - int'(acc_count)));
                item.last        = 1'b1;
                expected_bytes.push_back(item);
                acc_bits  = '0;
                acc_count = '0;
            end
            default: ;
        endcase
    endtask

    always @(posedge aclk) begin
        packed_out_t want;
        if (!aresetn) begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                code_bits[i] = '0;
                code_len[i]  = '0;
            end
            acc_bits  = '0;
            acc_count = '0;
            expected_bytes.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_bytes.size() == 0) begin
                    $error("packed byte %02h arrived with no byte expected", m_tdata);
                    mismatches++;
                end else begin
                    want = expected_bytes.pop_front();
                    if (m_tdata !== want.packed_byte) begin
                        $error("packed_byte: expected %02h, actual %02h",
                               want.packed_byte, m_tdata);
                        mismatches++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last: expected %0b, actual %0b", want.last, m_tlast);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                predict_packed_bytes(action_t'(s_tuser), s_tdata[7:0], s_tdata[39:8],
                                     s_tdata[45:40]);
        end
        bytes_awaited <= expected_bytes.size();
    end

endmodule

// ===== test/huffman_code_bit_packer_top_tb.sv =====
// Testbench top: clock, reset, stimulus, output back-pressure and the verdict.
`timescale 1ns / 1ps
module huffman_code_bit_packer_top_tb;
    import hcbp_pkg::*;

    localparam int ITEM_TARGET = 400;
    localparam int LONG_HOLD   = 100;
    localparam int QUIET_LIMIT = 2000;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    int bytes_awaited;
    int mismatches;
    int items_sent  = 0;
    int quiet_count = 0;
    bit steady      = 1'b0;
    bit hold_req    = 1'b0;
    bit hold_active = 1'b0;

    always #10 aclk = ~aclk;

    huffman_code_bit_packer_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    huffman_code_bit_packer_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .bytes_awaited (bytes_awaited),
        .mismatches    (mismatches)
    );

    // mostly short gaps, now and then a long one
    function automatic int idle_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    task automatic send_item(input action_t act, input logic [7:0] sym,
                             input logic [31:0] val, input logic [5:0] len);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {2'b00, len, val, sym};
        do @(posedge aclk); while (!s_tready);
        if (act != ACT_NONE)
            items_sent++;
        gap = idle_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (bytes_awaited != 0)
            @(posedge aclk);
    endtask

    task automatic random_item();
        int         r;
        logic [7:0] sym;
        logic [5:0] len;
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 5) == 0)
            sym = 8'($urandom_range(0, 255));
        else
            sym = 8'($urandom_range(0, 31));
        if (r < 10) begin
            r = $urandom_range(0, 99);
            if (r < 5)
                len = '0;
            else if (r < 65)
                len = 6'($urandom_range(1, 12));
            else if (r < 90)
                len = 6'($urandom_range(13, 32));
            else
                len = 6'($urandom_range(33, 63));
            send_item(ACT_LOAD, sym, $urandom, len);
        end else if (r < 22) begin
            send_item(ACT_FLUSH, 8'($urandom_range(0, 255)), $urandom,
                      6'($urandom_range(0, 63)));
        end else if (r < 25) begin
            send_item(ACT_NONE, 8'($urandom_range(0, 255)), $urandom,
                      6'($urandom_range(0, 63)));
        end else begin
            send_item(ACT_ENCODE, sym, $urandom, 6'($urandom_range(0, 63)));
        end
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        int gap;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_req) begin
                hold_req    = 1'b0;
                hold_active = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_active = 1'b0;
            end else begin
                gap = idle_gap();
                if (gap > 0) begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_count <= 0;
        else
            quiet_count <= quiet_count + 1;
        if (quiet_count >= QUIET_LIMIT) begin
            $display("FAIL huffman_code_bit_packer_top");
            $finish;
        end
    end

    initial begin
        bit paused = 1'b0;
        aresetn <= 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty table, empty flush, saturated lengths, ignored fields
        send_item(ACT_ENCODE, 8'd5, 32'h0, 6'd0);
        send_item(ACT_FLUSH, 8'd0, 32'h0, 6'd0);
        send_item(ACT_LOAD, 8'd0, 32'h0000FFFF, 6'd0);
        send_item(ACT_LOAD, 8'd255, 32'hFFFFFFFF, 6'd32);
        send_item(ACT_LOAD, 8'd1, 32'h00000000, 6'd32);
        send_item(ACT_LOAD, 8'd2, 32'h00000005, 6'd3);
        send_item(ACT_LOAD, 8'd3, 32'hFFFFFFFF, 6'd63);
        send_item(ACT_LOAD, 8'd4, 32'hA5A5A5A5, 6'd33);
        send_item(ACT_LOAD, 8'd6, 32'h00000001, 6'd1);
        send_item(ACT_ENCODE, 8'd255, 32'h0, 6'd0);
        send_item(ACT_ENCODE, 8'd2, 32'h0, 6'd0);
        send_item(ACT_ENCODE, 8'd255, 32'h0, 6'd0);
        send_item(ACT_ENCODE, 8'd3, 32'h0, 6'd0);
        send_item(ACT_ENCODE, 8'd0, 32'h0, 6'd0);
        send_item(ACT_FLUSH, 8'd0, 32'h0, 6'd0);
        send_item(ACT_ENCODE, 8'd6, 32'h0, 6'd0);
        send_item(ACT_FLUSH, 8'd0, 32'h0, 6'd0);
        send_item(ACT_NONE, 8'd2, 32'hFFFFFFFF, 6'd63);
        send_item(ACT_ENCODE, 8'd1, 32'h0, 6'd0);
        send_item(ACT_ENCODE, 8'd4, 32'h0, 6'd0);
        send_item(ACT_ENCODE, 8'd2, 32'hFFFFFFFF, 6'd63);
        send_item(ACT_FLUSH, 8'd255, 32'hFFFFFFFF, 6'd63);
        wait_drained();

        for (int i = 0; i < 32; i++)
            send_item(ACT_LOAD, 8'(i), $urandom, 6'($urandom_range(1, 16)));

        while (items_sent < ITEM_TARGET) begin
            if (items_sent >= 100 && !paused) begin
                paused = 1'b1;
                s_tvalid <= 1'b0;
                hold_req = 1'b1;
                while (!hold_active)
                    @(posedge aclk);
                steady = 1'b1;
                repeat (30)
                    send_item(ACT_ENCODE, 8'($urandom_range(0, 31)), $urandom,
                              6'($urandom_range(0, 63)));
                steady = 1'b0;
            end
            if (items_sent >= 250 && items_sent < 252)
                wait_drained();
            steady = (items_sent >= 300 && items_sent < 340);
            random_item();
        end
        steady = 1'b0;
        wait_drained();
        repeat (8) @(posedge aclk);

        if (mismatches == 0)
            $display("PASS huffman_code_bit_packer_top");
        else
            $display("FAIL huffman_code_bit_packer_top");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/hcbp_pkg.sv
rtl/hcbp_fifo.sv
rtl/hcbp_front.sv
rtl/hcbp_back.sv
rtl/huffman_code_bit_packer_top.sv
test/huffman_code_bit_packer_checker.sv
test/huffman_code_bit_packer_top_tb.sv
